// File: rtl/tcs_pkg.sv
// Shared constants for the text console with scroll.
// No dependencies; every other file but tcs_screen_ram uses these by scoped name.
package tcs_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int CELL_W  = CHAR_W + ATTR_W;
	localparam int INDEX_W = 11;
	localparam int OCOL_W  = 7;
	localparam int OROW_W  = 5;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CHAR_W-1:0] CODE_LF = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_CR = 8'd13;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// register word index, taken from paddr[2]
	localparam logic REG_TEXT_MODE = 1'b0;

endpackage

// File: rtl/tcs_if.sv
// Valid/ready channels of the text console: command items in, result items out.
// Depends on tcs_pkg for field widths.
interface tcs_cmd_if;
	logic                              valid;
	logic                              ready;
	logic                              opcode;
	logic [tcs_pkg::CHAR_W-1:0]        char_code;
	logic [tcs_pkg::ATTR_W-1:0]        color;
	logic [tcs_pkg::INDEX_W-1:0]       cell_index;

	modport source(output valid, opcode, char_code, color, cell_index, input ready);
	modport sink(input valid, opcode, char_code, color, cell_index, output ready);
endinterface

interface tcs_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [tcs_pkg::OCOL_W-1:0]        cursor_col;
	logic [tcs_pkg::OROW_W-1:0]        cursor_row;
	logic                              scrolled;
	logic [tcs_pkg::CHAR_W-1:0]        read_char;
	logic [tcs_pkg::ATTR_W-1:0]        read_attr;

	modport source(output valid, cursor_col, cursor_row, scrolled, read_char, read_attr,
		input ready);
	modport sink(input valid, cursor_col, cursor_row, scrolled, read_char, read_attr,
		output ready);
endinterface

// File: rtl/tcs_screen_ram.sv
// Screen cell store: one write port, one read port, registered read data.
// No package dependency.
module tcs_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/tcs_cfg_regs.sv
// APB-style configuration register file holding the text mode enable.
// Depends on tcs_pkg for address/data widths and register indexes.
module tcs_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcs_pkg::PADDR_W-1:0]  paddr,
	input  logic [tcs_pkg::PDATA_W-1:0]  pwdata,
	output logic [tcs_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic                         text_mode_enable
);

	logic en_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign text_mode_enable = en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
		end else if (wr && (paddr[2] == tcs_pkg::REG_TEXT_MODE)) begin
			en_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			tcs_pkg::REG_TEXT_MODE: prdata = {{(tcs_pkg::PDATA_W-1){1'b0}}, en_q};
			default:                prdata = '0;
		endcase
	end

endmodule

// File: rtl/text_console_with_scroll.sv
// Text console top level: cursor control, scroll/clear sweep, result register.
// Depends on tcs_pkg, tcs_if, tcs_screen_ram and tcs_cfg_regs.
//
// A put item without a scroll loads the result register straight from idle; a read
// item passes through S_READ, as the store returns the cell registered. A put that passes
// the last row copies the screen up one row and clears the bottom row, one
// cell per cycle through the store's write and read ports, during which
// commands are held off. After reset the same sweep zeroes the store, and
// no command is taken until it ends; register writes are taken at any time.
module text_console_with_scroll #(
	parameter int COLUMNS = tcs_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcs_pkg::ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcs_pkg::PADDR_W-1:0]  paddr,
	input  logic [tcs_pkg::PDATA_W-1:0]  pwdata,
	output logic [tcs_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	tcs_cmd_if.sink                      cmd,
	tcs_rsp_if.source                    rsp
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int COPY  = COLUMNS * (ROWS - 1);
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = $clog2(CELLS + 1);
	localparam int CW    = $clog2(COLUMNS + 1);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int IXW   = AW + tcs_pkg::INDEX_W;
	localparam int CXW   = CW + tcs_pkg::OCOL_W;
	localparam int RXW   = RW + tcs_pkg::OROW_W;
	localparam int DW    = tcs_pkg::CELL_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	state_t        state_q;
	logic          clear_q;
	logic [PW-1:0] ptr_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          wr_v_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          wr_zero_s1;
	logic          rd_ok_s1;

	logic                       out_valid_q;
	logic [CW-1:0]              out_col_q;
	logic [RW-1:0]              out_row_q;
	logic                       out_scr_q;
	logic [tcs_pkg::CHAR_W-1:0] out_char_q;
	logic [tcs_pkg::ATTR_W-1:0] out_attr_q;

	logic          text_en;
	logic          accept;
	logic          is_nl;
	logic          adv;
	logic [CW-1:0] col_inc;
	logic [RW-1:0] row_inc;
	logic          wrap;
	logic          scroll;
	logic [CW-1:0] col_n;
	logic [RW-1:0] row_n;
	logic [PW-1:0] put_pos;
	logic [PW-1:0] src_pos;
	logic [IXW-1:0] idx_wide;
	logic          idx_ok;
	logic [CXW-1:0] col_wide;
	logic [RXW-1:0] row_wide;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [DW-1:0] mem_rdata;

	tcs_cfg_regs u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.text_mode_enable (text_en)
	);

	tcs_screen_ram #(
		.DEPTH (CELLS),
		.AW    (AW),
		.DW    (DW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign cmd.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = cmd.valid && cmd.ready;

	// cursor step for a put item
	assign is_nl   = (cmd.char_code == tcs_pkg::CODE_LF) || (cmd.char_code == tcs_pkg::CODE_CR);
	assign adv     = !is_nl && text_en;
	assign col_inc = col_q + CW'(1);
	assign row_inc = row_q + RW'(1);
	assign wrap    = is_nl || (adv && (col_inc == CW'(COLUMNS)));
	assign scroll  = wrap && (row_inc == RW'(ROWS));
	assign col_n   = wrap ? '0 : (adv ? col_inc : col_q);
	assign row_n   = wrap ? (scroll ? RW'(ROWS - 1) : row_inc) : row_q;

	assign put_pos  = PW'(row_q) * PW'(COLUMNS) + PW'(col_q);
	assign src_pos  = ptr_q + PW'(COLUMNS);
	assign idx_wide = IXW'(cmd.cell_index);
	assign idx_ok   = idx_wide < IXW'(CELLS);

	// sweep writes go first; a put only writes while idle
	assign mem_we    = wr_v_s1 || (accept && (cmd.opcode == tcs_pkg::OP_PUT) && adv);
	assign mem_waddr = wr_v_s1 ? wr_addr_s1 : put_pos[AW-1:0];
	assign mem_wdata = wr_v_s1 ? (wr_zero_s1 ? '0 : mem_rdata) : {cmd.color, cmd.char_code};
	assign mem_raddr = (state_q == S_SWEEP) ? src_pos[AW-1:0] : idx_wide[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			clear_q     <= 1'b1;
			ptr_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			wr_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.opcode == tcs_pkg::OP_READ) begin
							state_q <= S_READ;
						end else begin
							col_q <= col_n;
							row_q <= row_n;
							if (scroll) begin
								state_q <= S_SWEEP;
								ptr_q   <= '0;
							end else begin
								out_valid_q <= 1'b1;
							end
						end
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SWEEP: begin
					wr_v_s1 <= 1'b1;
					ptr_q   <= ptr_q + PW'(1);
					if (ptr_q == PW'(CELLS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					wr_v_s1 <= 1'b0;
					clear_q <= 1'b0;
					if (!clear_q) begin
						out_valid_q <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= ptr_q[AW-1:0];
		wr_zero_s1 <= clear_q || (ptr_q >= PW'(COPY));
		if (accept) begin
			rd_ok_s1 <= idx_ok;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					out_col_q  <= col_n;
					out_row_q  <= row_n;
					out_scr_q  <= 1'b0;
					out_char_q <= '0;
					out_attr_q <= '0;
					if (cmd.opcode == tcs_pkg::OP_READ) begin
						out_col_q <= col_q;
						out_row_q <= row_q;
					end
				end
			end
			S_READ: begin
				out_col_q  <= col_q;
				out_row_q  <= row_q;
				out_scr_q  <= 1'b0;
				out_char_q <= rd_ok_s1 ? mem_rdata[tcs_pkg::CHAR_W-1:0] : '0;
				out_attr_q <= rd_ok_s1 ? mem_rdata[DW-1:tcs_pkg::CHAR_W] : '0;
			end
			S_DRAIN: begin
				out_col_q  <= col_q;
				out_row_q  <= row_q;
				out_scr_q  <= 1'b1;
				out_char_q <= '0;
				out_attr_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// payload loads on each accepted item, in S_READ and in S_DRAIN, also when no result is flagged
	assign col_wide = CXW'(out_col_q);
	assign row_wide = RXW'(out_row_q);

	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_col = col_wide[tcs_pkg::OCOL_W-1:0];
	assign rsp.cursor_row = row_wide[tcs_pkg::OROW_W-1:0];
	assign rsp.scrolled   = out_scr_q;
	assign rsp.read_char  = out_char_q;
	assign rsp.read_attr  = out_attr_q;

endmodule

// File: tb/console_checker.sv
// Checker for the text console: watches the command, result and register ports,
// keeps its own screen, cursor and text mode, and compares every result item in order.
// Depends on tcs_pkg and the tcs_cmd_if / tcs_rsp_if interfaces.
module console_checker #(
	parameter int COLUMNS = tcs_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcs_pkg::ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tcs_pkg::PADDR_W-1:0]  paddr,
	input  logic [tcs_pkg::PDATA_W-1:0]  pwdata,
	input  logic [tcs_pkg::PDATA_W-1:0]  prdata,
	input  logic                         pready,
	tcs_cmd_if                           cmd,
	tcs_rsp_if                           rsp,
	output int                           fail_count,
	output int                           pending,
	output int                           scroll_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELL_COUNT = COLUMNS * ROWS;

	typedef struct packed {
		logic [tcs_pkg::OCOL_W-1:0] col;
		logic [tcs_pkg::OROW_W-1:0] row;
		logic                       scrolled;
		logic [tcs_pkg::CHAR_W-1:0] rd_char;
		logic [tcs_pkg::ATTR_W-1:0] rd_attr;
	} console_out_t;

	logic [tcs_pkg::CELL_W-1:0] cells [CELL_COUNT];
	int unsigned                cur_col;
	int unsigned                cur_row;
	logic                       text_mode;
	console_out_t               console_out_q [$];
	console_out_t               got;
	console_out_t               want;
	int                         cmd_count;
	int                         rsp_count;

	assign pending = cmd_count - rsp_count;

	task automatic report_mismatch(input string what, input int unsigned seen,
		input int unsigned due);
		fail_count++;
		$display("%0t: mismatch on %s at result %0d: got %0d, want %0d",
			$realtime, what, rsp_count, seen, due);
	endtask

	// column 0 of the next row; past the last row the screen moves up one row
	function automatic bit next_line();
		cur_col = 0;
		cur_row++;
		if (cur_row < ROWS)
			return 1'b0;
		for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
			cells[i] = cells[i + COLUMNS];
		for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
			cells[i] = '0;
		cur_row = ROWS - 1;
		return 1'b1;
	endfunction

	function automatic console_out_t advance_console(input logic op,
		input logic [tcs_pkg::CHAR_W-1:0] code, input logic [tcs_pkg::ATTR_W-1:0] attr,
		input logic [tcs_pkg::INDEX_W-1:0] idx);
		console_out_t r;
		r = '0;
		if (op == tcs_pkg::OP_READ) begin
			if (int'(idx) < CELL_COUNT) begin
				r.rd_char = cells[idx][tcs_pkg::CHAR_W-1:0];
				r.rd_attr = cells[idx][tcs_pkg::CELL_W-1:tcs_pkg::CHAR_W];
			end
		end else if (code == tcs_pkg::CODE_LF || code == tcs_pkg::CODE_CR) begin
			r.scrolled = next_line();
		end else if (text_mode) begin
			cells[cur_row * COLUMNS + cur_col] = {attr, code};
			cur_col++;
			if (cur_col >= COLUMNS)
				r.scrolled = next_line();
		end
		r.col = cur_col[tcs_pkg::OCOL_W-1:0];
		r.row = cur_row[tcs_pkg::OROW_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELL_COUNT; i++)
				cells[i] = '0;
			cur_col = 0;
			cur_row = 0;
			text_mode = 1'b1;
			console_out_q.delete();
			fail_count = 0;
			scroll_count = 0;
			cmd_count <= 0;
			rsp_count <= 0;
		end else begin
			if (psel && penable && pready &&
				paddr[tcs_pkg::PADDR_W-1:2] == tcs_pkg::REG_TEXT_MODE) begin
				if (pwrite)
					text_mode = pwdata[0];
				else if (prdata != {{(tcs_pkg::PDATA_W-1){1'b0}}, text_mode})
					report_mismatch("text mode readback", prdata, text_mode);
			end

			if (cmd.valid && cmd.ready) begin
				want = advance_console(cmd.opcode, cmd.char_code, cmd.color, cmd.cell_index);
				if (want.scrolled)
					scroll_count++;
				console_out_q.push_back(want);
				cmd_count <= cmd_count + 1;
			end

			if (rsp.valid && rsp.ready) begin
				got = {rsp.cursor_col, rsp.cursor_row, rsp.scrolled, rsp.read_char,
					rsp.read_attr};
				rsp_count <= rsp_count + 1;
				if (console_out_q.size() == 0) begin
					report_mismatch("result item with none due", 1, 0);
				end else begin
					want = console_out_q.pop_front();
					if (got.col != want.col)
						report_mismatch("cursor_col", got.col, want.col);
					if (got.row != want.row)
						report_mismatch("cursor_row", got.row, want.row);
					if (got.scrolled != want.scrolled)
						report_mismatch("scrolled", got.scrolled, want.scrolled);
					if (got.rd_char != want.rd_char)
						report_mismatch("read_char", got.rd_char, want.rd_char);
					if (got.rd_attr != want.rd_attr)
						report_mismatch("read_attr", got.rd_attr, want.rd_attr);
				end
			end
		end
	end

endmodule

// File: tb/text_console_with_scroll_tb.sv
// Top of the text console bench: clock, reset, command and register stimulus,
// result back-pressure and the verdict. Depends on tcs_pkg, tcs_if, the console
// RTL and console_checker.
module text_console_with_scroll_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS        = tcs_pkg::COLUMNS_DEF * tcs_pkg::ROWS_DEF;
	localparam int RANDOM_ITEMS = 1250;
	localparam int N_PHASES     = 6;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = CELLS + 100;
	// every item scrolling plus worst gaps and stalls, a few times over
	localparam int LIMIT_CYCLES = 10_000_000;

	localparam logic [tcs_pkg::PADDR_W-1:0] ADDR_TEXT_MODE = {tcs_pkg::REG_TEXT_MODE, 2'b00};
	localparam logic [tcs_pkg::PADDR_W-1:0] ADDR_UNMAPPED  = {~tcs_pkg::REG_TEXT_MODE, 2'b00};

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [tcs_pkg::PADDR_W-1:0]  paddr;
	logic [tcs_pkg::PDATA_W-1:0]  pwdata;
	logic [tcs_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;

	tcs_cmd_if cmd_ch();
	tcs_rsp_if rsp_ch();

	int fail_count;
	int pending;
	int scroll_count;
	int n_sent;
	int n_reads;
	int n_mode_writes;
	int burst_left;
	int cycles;

	text_console_with_scroll u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch)
	);

	console_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.cmd          (cmd_ch),
		.rsp          (rsp_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.scroll_count (scroll_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [tcs_pkg::INDEX_W-1:0] rand_index();
		return tcs_pkg::INDEX_W'($urandom_range(0, 2047));
	endfunction

	function automatic logic [7:0] newline_code();
		return ($urandom_range(0, 1) == 1) ? tcs_pkg::CODE_LF : tcs_pkg::CODE_CR;
	endfunction

	// sender works in bursts separated by random gaps
	task automatic send_item(input logic op, input logic [7:0] code, input logic [7:0] attr,
		input logic [tcs_pkg::INDEX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.opcode     <= op;
		cmd_ch.char_code  <= code;
		cmd_ch.color      <= attr;
		cmd_ch.cell_index <= idx;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		burst_left--;
		n_sent++;
		if (op == tcs_pkg::OP_READ)
			n_reads++;
	endtask

	task automatic apb_access(input logic wr, input logic [tcs_pkg::PADDR_W-1:0] addr,
		input logic [tcs_pkg::PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// only once every result is back; the unmapped write must be ignored
	task automatic set_text_mode(input logic en);
		logic [tcs_pkg::PDATA_W-1:0] word;
		word = $urandom;
		word[0] = en;
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		apb_access(1'b1, ADDR_TEXT_MODE, word);
		apb_access(1'b1, ADDR_UNMAPPED, $urandom);
		apb_access(1'b0, ADDR_TEXT_MODE, '0);
		n_mode_writes++;
	endtask

	initial begin : receiver
		int duty;
		bit held;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!held && n_sent >= HOLD_AT) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			duty = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(30, 90);
			repeat ($urandom_range(1, 40)) begin
				rsp_ch.ready <= ($urandom_range(0, 99) < duty);
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("no progress after %0d cycles", cycles);
		$display("text_console_with_scroll test failed");
		$finish;
	end

	initial begin : stimulus
		int target;
		int kind;
		int len;
		logic [tcs_pkg::INDEX_W-1:0] idx;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.opcode     <= tcs_pkg::OP_PUT;
		cmd_ch.char_code  <= '0;
		cmd_ch.color      <= '0;
		cmd_ch.cell_index <= '0;
		n_sent = 0;
		n_reads = 0;
		n_mode_writes = 0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, ADDR_TEXT_MODE, '0);

		// cleared screen, index extremes, out-of-range reads
		send_item(tcs_pkg::OP_READ, 8'h00, 8'h00, '0);
		send_item(tcs_pkg::OP_READ, 8'hFF, 8'hFF, tcs_pkg::INDEX_W'(CELLS - 1));
		send_item(tcs_pkg::OP_READ, 8'h00, 8'hFF, tcs_pkg::INDEX_W'(CELLS));
		send_item(tcs_pkg::OP_READ, 8'hFF, 8'h00, '1);
		// code zero, byte extremes, line moves, codes around LF and CR
		send_item(tcs_pkg::OP_PUT, 8'h00, 8'h00, '1);
		send_item(tcs_pkg::OP_PUT, 8'hFF, 8'hFF, '0);
		send_item(tcs_pkg::OP_PUT, 8'h41, 8'h1F, '0);
		send_item(tcs_pkg::OP_PUT, tcs_pkg::CODE_CR, 8'h07, '0);
		send_item(tcs_pkg::OP_PUT, tcs_pkg::CODE_LF, 8'h70, '1);
		send_item(tcs_pkg::OP_PUT, 8'h09, 8'hAA, '0);
		send_item(tcs_pkg::OP_PUT, 8'h0B, 8'h55, '0);
		send_item(tcs_pkg::OP_PUT, 8'h0C, 8'h55, '0);
		send_item(tcs_pkg::OP_PUT, 8'h0E, 8'h55, '0);
		send_item(tcs_pkg::OP_READ, 8'h00, 8'h00, 11'd0);
		send_item(tcs_pkg::OP_READ, 8'h00, 8'h00, 11'd1);
		send_item(tcs_pkg::OP_READ, 8'h00, 8'h00, 11'd2);
		send_item(tcs_pkg::OP_READ, 8'h00, 8'h00, tcs_pkg::INDEX_W'(2 * tcs_pkg::COLUMNS_DEF));
		// read carrying a newline code must not move the cursor
		send_item(tcs_pkg::OP_READ, tcs_pkg::CODE_LF, 8'h00,
			tcs_pkg::INDEX_W'(2 * tcs_pkg::COLUMNS_DEF + 1));

		// text mode off: printable codes ignored, line moves still act
		set_text_mode(1'b0);
		send_item(tcs_pkg::OP_PUT, 8'h42, 8'h1E, '0);
		send_item(tcs_pkg::OP_PUT, 8'h00, 8'hFF, '0);
		send_item(tcs_pkg::OP_PUT, tcs_pkg::CODE_LF, 8'h00, '0);
		send_item(tcs_pkg::OP_READ, 8'h00, 8'h00, tcs_pkg::INDEX_W'(2 * tcs_pkg::COLUMNS_DEF + 2));
		set_text_mode(1'b1);

		// random: lines of text, read bursts and blank-line runs, per mode phase
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph > 0)
				set_text_mode((ph % 3) != 1);
			target = n_sent + RANDOM_ITEMS / N_PHASES;
			while (n_sent < target) begin
				kind = $urandom_range(0, 99);
				if (kind < 60) begin
					len = ($urandom_range(0, 6) == 0)
						? $urandom_range(tcs_pkg::COLUMNS_DEF - 5, tcs_pkg::COLUMNS_DEF + 5)
						: $urandom_range(0, 40);
					repeat (len)
						send_item(tcs_pkg::OP_PUT, rand_byte(), rand_byte(), rand_index());
					if ($urandom_range(0, 4) != 0)
						send_item(tcs_pkg::OP_PUT, newline_code(), rand_byte(), rand_index());
				end else if (kind < 85) begin
					repeat ($urandom_range(1, 6)) begin
						case ($urandom_range(0, 9))
							0, 1, 2, 3: idx = tcs_pkg::INDEX_W'($urandom_range(
								CELLS - 5 * tcs_pkg::COLUMNS_DEF, CELLS - 1));
							4, 5, 6, 7, 8: idx = tcs_pkg::INDEX_W'($urandom_range(0, CELLS - 1));
							default: idx = tcs_pkg::INDEX_W'($urandom_range(CELLS, 2047));
						endcase
						send_item(tcs_pkg::OP_READ, rand_byte(), rand_byte(), idx);
					end
				end else begin
					repeat ($urandom_range(1, 5))
						send_item(tcs_pkg::OP_PUT, newline_code(), rand_byte(), rand_index());
				end
			end
		end

		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items (%0d reads) with %0d scrolls over %0d text mode settings,",
			n_sent, n_reads, scroll_count, n_mode_writes + 1);
		$display("with bursty input, random result stalls and one long result hold-off");
		if (fail_count == 0 && pending == 0) begin
			$display("text_console_with_scroll test passed");
		end else begin
			$display("text_console_with_scroll test failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/tcs_pkg.sv
rtl/tcs_if.sv
rtl/tcs_screen_ram.sv
rtl/tcs_cfg_regs.sv
rtl/text_console_with_scroll.sv
tb/console_checker.sv
tb/text_console_with_scroll_tb.sv
